FILE: hdl/cpr_pkg.sv
// Package for the clock page replacement block: fixed field widths, the
// transaction payload types and the controller command and state types.
// No dependencies.
package cpr_pkg;

    localparam int PAGE_W  = 16;
    localparam int REF_W   = 8;
    localparam int FIDX_W  = 3;
    localparam int FAULT_W = 16;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

    typedef struct packed {
        logic [PAGE_W-1:0] page;
        logic [REF_W-1:0]  ref_bits;
    } item_t;

    typedef struct packed {
        logic               hit;
        logic [FIDX_W-1:0]  frame_index;
        logic               evicted_valid;
        logic [PAGE_W-1:0]  evicted_page;
        logic [FAULT_W-1:0] fault_count;
    } result_t;

    typedef enum logic {
        ST_IDLE,
        ST_UPDATE
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

endpackage

FILE: hdl/cpr_ifs.sv
// Valid/ready channel interfaces for the clock page replacement block.
// Depends on cpr_pkg for the payload types.
interface cpr_item_if
    import cpr_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cpr_result_if
    import cpr_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/cpr_ctrl.sv
// Controller state machine for the clock page replacement block.
// Depends on cpr_pkg for the state and command types.
module cpr_ctrl
    import cpr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd.capture    = 1'b0;
        cmd.commit     = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                if (in_valid)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                // The result register must be free or emptying this cycle.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/cpr_datapath.sv
// Datapath for the clock page replacement block: frame table, reference
// flags, clock hand, fault counter, match register and result register.
// Depends on cpr_pkg for widths, payload and command types.
module cpr_datapath
    import cpr_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  item_t            item_data,
    input  cmd_t             cmd,
    output result_t          result_data
);

    localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W = $clog2(FRAMES + 1);

    logic [CFG_W-1:0]     frames_in_use_reg;
    logic [PAGE_BITS-1:0] frame_page_reg [FRAMES];
    logic [FRAMES-1:0]    frame_valid_reg;
    logic [FRAMES-1:0]    ref_flag_reg;
    logic [FRAMES-1:0]    ref_flag_next;
    logic [IDX_W-1:0]     hand_reg;
    logic [IDX_W-1:0]     hand_next;
    logic [FAULT_W-1:0]   faults_reg;
    logic [FAULT_W-1:0]   faults_next;
    logic [PAGE_BITS-1:0] page_reg;
    logic [REF_W-1:0]     bits_reg;
    logic [FRAMES-1:0]    match_reg;
    logic [FRAMES-1:0]    match_next;
    result_t              result_reg;
    result_t              result_next;

    logic [CNT_W-1:0]     count;
    logic [FRAMES-1:0]    active;
    logic [PAGE_BITS-1:0] page_in;
    logic                 hit;
    logic [IDX_W-1:0]     hit_idx;
    logic [FRAMES-1:0]    loaded;
    logic [FRAMES-1:0]    clear_slot;
    logic [IDX_W-1:0]     hand_eff;
    logic                 found_hi;
    logic                 found_lo;
    logic [IDX_W-1:0]     idx_hi;
    logic [IDX_W-1:0]     idx_lo;
    logic [IDX_W-1:0]     victim;
    logic [CNT_W-1:0]     victim_plus;
    logic [FRAMES-1:0]    swept;

    // Effective frame count: zero acts as one, anything above FRAMES as FRAMES.
    always_comb
    begin
        if (frames_in_use_reg == '0)
        begin
            count = CNT_W'(1);
        end
        else if (32'(frames_in_use_reg) > FRAMES)
        begin
            count = CNT_W'(FRAMES);
        end
        else
        begin
            count = CNT_W'(frames_in_use_reg);
        end
    end

    assign page_in = PAGE_BITS'(item_data.page);

    for (genvar g = 0; g < FRAMES; g++)
    begin : g_frame
        assign active[g]     = (g < int'(count));
        assign match_next[g] = frame_valid_reg[g] && active[g] &&
                               (frame_page_reg[g] == page_in);
        if (g < REF_W)
        begin : g_bit
            assign loaded[g] = bits_reg[g];
        end
        else
        begin : g_nobit
            assign loaded[g] = 1'b0;
        end
        assign clear_slot[g] = active[g] && !loaded[g];
    end

    assign hand_eff = (CNT_W'(hand_reg) < count) ? hand_reg : '0;

    // Lowest matching frame and the rotated search for the first clear flag.
    always_comb
    begin
        hit_idx  = '0;
        idx_hi   = '0;
        idx_lo   = '0;
        found_hi = 1'b0;
        found_lo = 1'b0;
        for (int i = FRAMES - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (clear_slot[i])
            begin
                found_lo = 1'b1;
                idx_lo   = IDX_W'(i);
                if (i >= int'(hand_eff))
                begin
                    found_hi = 1'b1;
                    idx_hi   = IDX_W'(i);
                end
            end
        end
        hit = |match_reg;
    end

    assign victim      = found_hi ? idx_hi : (found_lo ? idx_lo : hand_eff);
    assign victim_plus = CNT_W'(victim) + CNT_W'(1);
    assign hand_next   = (victim_plus >= count) ? '0 : IDX_W'(victim_plus);
    assign faults_next = (faults_reg == '1) ? faults_reg : faults_reg + FAULT_W'(1);

    // Flags the hand passed over are cleared; with every active flag set,
    // the hand goes all the way round and clears them all.
    always_comb
    begin
        for (int i = 0; i < FRAMES; i++)
        begin
            if (!found_lo)
            begin
                swept[i] = active[i];
            end
            else if (victim >= hand_eff)
            begin
                swept[i] = active[i] && (i >= int'(hand_eff)) && (i < int'(victim));
            end
            else
            begin
                swept[i] = active[i] && ((i >= int'(hand_eff)) || (i < int'(victim)));
            end
            ref_flag_next[i] = loaded[i] && !swept[i] && (i != int'(victim));
        end
    end

    always_comb
    begin
        result_next.fault_count = hit ? faults_reg : faults_next;
        result_next.hit         = hit;
        if (hit)
        begin
            result_next.frame_index   = FIDX_W'(hit_idx);
            result_next.evicted_valid = 1'b0;
            result_next.evicted_page  = '0;
        end
        else
        begin
            result_next.frame_index   = FIDX_W'(victim);
            result_next.evicted_valid = frame_valid_reg[victim];
            result_next.evicted_page  = frame_valid_reg[victim] ?
                                        PAGE_W'(frame_page_reg[victim]) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frames_in_use_reg <= CFG_RESET;
            frame_valid_reg   <= '0;
            ref_flag_reg      <= '0;
            hand_reg          <= '0;
            faults_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                frames_in_use_reg <= cfg_wdata;
            end
            if (cmd.commit)
            begin
                if (hit)
                begin
                    ref_flag_reg[hit_idx] <= 1'b1;
                end
                else
                begin
                    frame_valid_reg[victim] <= 1'b1;
                    ref_flag_reg            <= ref_flag_next;
                    hand_reg                <= hand_next;
                    faults_reg              <= faults_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            page_reg  <= page_in;
            bits_reg  <= item_data.ref_bits;
            match_reg <= match_next;
        end
        if (cmd.commit)
        begin
            result_reg <= result_next;
            if (!hit)
            begin
                frame_page_reg[victim] <= page_reg;
            end
        end
    end

    assign result_data = result_reg;

endmodule

FILE: hdl/clock_page_replacement_top.sv
// Top level of the clock page replacement block.
// Depends on cpr_pkg, cpr_ifs, cpr_ctrl and cpr_datapath.
//
// Usage:
// The item channel carries one page reference per transaction: the page
// number and a reference bit per frame that is loaded only on a page fault.
// The result channel returns exactly one transaction per reference: hit or
// fault, the frame now holding the page, the page evicted (if any) and the
// saturating fault count including this reference.
// The frames_in_use register is written through cfg_we and cfg_wdata; the
// user is to write it only while the block is idle, which the block itself
// leaves unchecked. Zero acts as one frame and values above FRAMES act as FRAMES.
// Timing: an item is compared against every frame in the cycle it is
// accepted; the clock-hand search and state update follow in the update
// state once the result register is free, which loads the result. Each item
// passes the compare step and the update step of the single datapath; the
// next item is taken in the cycle after the result is loaded.
// Reset empties every frame, clears all reference flags, the hand and the
// fault count, and sets frames_in_use to 8.
// When the receiver stalls, the result is held in its output register and
// one further item may be accepted; that item then waits in its update cycle
// until the result register is free.
module clock_page_replacement_top
    import cpr_pkg::*;
#(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    cpr_item_if.sink         item,
    cpr_result_if.source     result
);

    cmd_t cmd;
    logic in_ready;
    logic out_valid;

    // The controller sequences each transaction: capture, then commit once the
    // result register can take the answer.
    cpr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (item.valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // The datapath holds the frame table and computes hit or victim.
    cpr_datapath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .item_data   (item.data),
        .cmd         (cmd),
        .result_data (result.data)
    );

    assign item.ready   = in_ready;
    assign result.valid = out_valid;

endmodule

FILE: hdl/cpr_checker.sv
// Port-level checker for the clock page replacement block, bound to the top.
// Depends on cpr_pkg for field widths.
module cpr_checker
    import cpr_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              out_hit,
    input logic              out_evicted_valid,
    input logic [PAGE_W-1:0] out_evicted_page
);

    // A result waiting to be taken must stay offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

    // Only one reference is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("item accepted while another is in work");

    // A hit never evicts a page.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_hit |-> !out_evicted_valid && (out_evicted_page == '0))
    else $error("hit result reports an eviction");

    // The evicted page field is zero when nothing was evicted.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_evicted_valid |-> (out_evicted_page == '0))
    else $error("evicted page nonzero without eviction");

endmodule

bind clock_page_replacement_top cpr_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (item.valid),
    .in_ready          (item.ready),
    .out_valid         (result.valid),
    .out_ready         (result.ready),
    .out_hit           (result.data.hit),
    .out_evicted_valid (result.data.evicted_valid),
    .out_evicted_page  (result.data.evicted_page)
);
